/* src/sls_pkg.sv */
// types, constants and time-stamp arithmetic shared by the stopwatch files
package sls_pkg;

  typedef enum logic [1:0] {
    CmdSelect     = 2'd0,
    CmdLongSelect = 2'd1,
    CmdUp         = 2'd2,
    CmdRefresh    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ModeStart     = 3'd0,
    ModeRun       = 3'd1,
    ModeSplit     = 3'd2,
    ModeLap       = 3'd3,
    ModeStopLap   = 3'd4,
    ModeStopSplit = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    CfgFastLimit    = 2'd0,
    CfgFastInterval = 2'd1,
    CfgSlowInterval = 2'd2
  } cfg_idx_e;

  localparam logic [1:0] TitleMain  = 2'd0;
  localparam logic [1:0] TitleSplit = 2'd1;
  localparam logic [1:0] TitleLap   = 2'd2;

  localparam logic [9:0]  MsPerSec  = 10'd1000;
  localparam logic [9:0]  MsMax     = 10'd999;
  localparam logic [9:0]  MsRound   = 10'd100;

  localparam logic [15:0] ResetFastLimitSec   = 16'd300;
  localparam logic [15:0] ResetFastIntervalMs = 16'd200;
  localparam logic [15:0] ResetSlowIntervalMs = 16'd1000;

  typedef struct packed {
    logic [31:0] s;
    logic [9:0]  m;
  } tstamp_t;

  localparam tstamp_t StampZero = '{s: 32'd0, m: 10'd0};

  function automatic tstamp_t t_sub(tstamp_t a, tstamp_t b);
    tstamp_t r;
    r.s = a.s - b.s;
    if (a.m < b.m) begin
      r.m = a.m + MsPerSec - b.m;
      r.s = r.s - 32'd1;
    end else begin
      r.m = a.m - b.m;
    end
    return r;
  endfunction

  function automatic tstamp_t t_add(tstamp_t a, tstamp_t b);
    tstamp_t     r;
    logic [10:0] sum;
    sum = {1'b0, a.m} + {1'b0, b.m};
    r.s = a.s + b.s;
    if (sum >= {1'b0, MsPerSec}) begin
      r.m = 10'(sum - {1'b0, MsPerSec});
      r.s = r.s + 32'd1;
    end else begin
      r.m = sum[9:0];
    end
    return r;
  endfunction

endpackage

/* src/sls_if.sv */
// request channels of the stopwatch: command input, display output, register writes
interface sls_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] now_sec;
  logic [9:0]  now_ms;

  modport source (output valid, output command, output now_sec, output now_ms, input ready);
  modport sink   (input valid, input command, input now_sec, input now_ms, output ready);
endinterface

interface sls_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] shown_sec;
  logic [9:0]  shown_ms;
  logic [1:0]  title_code;
  logic        paused_mark;
  logic        accepted;
  logic        running;
  logic [15:0] redraw_interval_ms;

  modport source (output valid, output shown_sec, output shown_ms, output title_code,
                  output paused_mark, output accepted, output running,
                  output redraw_interval_ms, input ready);
  modport sink   (input valid, input shown_sec, input shown_ms, input title_code,
                  input paused_mark, input accepted, input running,
                  input redraw_interval_ms, output ready);
endinterface

interface sls_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/split_lap_stopwatch_top.sv */
// stopwatch with split and lap capture, one command per request
// Takes one command request per clock and returns one display request for it; the
// mode update, time-stamp arithmetic and display formatting all happen in the
// accepting cycle and land in an output register, so the result appears in the cycle
// after acceptance. A new command is taken every cycle as long as the output register
// is empty or being drained; a stalled output holds back only the input, one request
// deep. Register writes are always taken and should be made while no request is open.
module split_lap_stopwatch_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  sls_in_if.sink    in_i,
  sls_out_if.source out_o,
  sls_cfg_if.sink   cfg_i
);

  sls_pkg::mode_e   mode_q, mode_d;
  sls_pkg::tstamp_t start_q, start_d;
  sls_pkg::tstamp_t last_q, last_d;
  sls_pkg::tstamp_t split_q, split_d;
  sls_pkg::tstamp_t lap_q, lap_d;
  sls_pkg::tstamp_t pause_q, pause_d;

  logic [15:0] fast_limit_q, fast_int_q, slow_int_q;

  logic        out_valid_q;
  logic [31:0] sec_q, sec_d;
  logic [9:0]  ms_q, ms_d;
  logic [1:0]  title_q, title_d;
  logic        pmark_q, pmark_d;
  logic        acc_q, acc_d;
  logic        run_q, run_d;
  logic [15:0] redraw_q, redraw_d;

  logic             in_fire;
  logic             cap;
  sls_pkg::tstamp_t now, span, el, el_a, el_b;
  logic [15:0]      prod;
  logic [3:0]       hund;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    now.s = in_i.now_sec;
    now.m = (in_i.now_ms > sls_pkg::MsMax) ? sls_pkg::MsMax : in_i.now_ms;
    span  = sls_pkg::t_sub(now, pause_q);

    mode_d  = mode_q;
    start_d = start_q;
    last_d  = last_q;
    split_d = split_q;
    lap_d   = lap_q;
    pause_d = pause_q;
    acc_d   = 1'b1;
    cap     = 1'b0;
    el_a    = now;
    el_b    = start_q;

    case (sls_pkg::cmd_e'(in_i.command))
      sls_pkg::CmdSelect: begin
        case (mode_q)
          sls_pkg::ModeRun: begin
            pause_d = now;
            cap     = 1'b1;
            mode_d  = sls_pkg::ModeStopSplit;
          end
          sls_pkg::ModeStopLap, sls_pkg::ModeStopSplit: begin
            start_d = sls_pkg::t_add(span, start_q);
            last_d  = sls_pkg::t_add(span, last_q);
            mode_d  = sls_pkg::ModeRun;
            el_a    = pause_q;
          end
          sls_pkg::ModeSplit, sls_pkg::ModeLap: begin
            mode_d = sls_pkg::ModeRun;
          end
          default: begin
            start_d = now;
            last_d  = now;
            mode_d  = sls_pkg::ModeRun;
            el_b    = now;
          end
        endcase
      end
      sls_pkg::CmdLongSelect: begin
        start_d = sls_pkg::StampZero;
        last_d  = sls_pkg::StampZero;
        split_d = sls_pkg::StampZero;
        lap_d   = sls_pkg::StampZero;
        pause_d = sls_pkg::StampZero;
        mode_d  = sls_pkg::ModeStart;
      end
      sls_pkg::CmdUp: begin
        case (mode_q)
          sls_pkg::ModeRun: begin
            cap    = 1'b1;
            mode_d = sls_pkg::ModeSplit;
          end
          sls_pkg::ModeStopLap:   mode_d = sls_pkg::ModeStopSplit;
          sls_pkg::ModeStopSplit: mode_d = sls_pkg::ModeStopLap;
          sls_pkg::ModeSplit:     mode_d = sls_pkg::ModeLap;
          sls_pkg::ModeLap:       mode_d = sls_pkg::ModeSplit;
          default:                acc_d  = 1'b0;
        endcase
      end
      default: ;
    endcase

    if (cap) begin
      lap_d   = sls_pkg::t_sub(now, last_q);
      split_d = sls_pkg::t_sub(now, start_q);
      last_d  = now;
    end

    // elapsed time for the run view, against the updated start stamp
    el   = sls_pkg::t_sub(el_a, el_b);
    prod = 16'(el.m) * 16'd41;
    hund = prod[15:12];

    sec_d    = 32'd0;
    ms_d     = 10'd0;
    title_d  = sls_pkg::TitleMain;
    pmark_d  = 1'b0;
    run_d    = 1'b0;
    redraw_d = 16'd0;
    case (mode_d)
      sls_pkg::ModeRun: begin
        sec_d    = el.s;
        ms_d     = 10'(({6'd0, hund} + 10'd1) * sls_pkg::MsRound);
        run_d    = 1'b1;
        redraw_d = (el.s < {16'd0, fast_limit_q}) ? fast_int_q : slow_int_q;
      end
      sls_pkg::ModeSplit: begin
        sec_d   = split_d.s;
        ms_d    = split_d.m;
        title_d = sls_pkg::TitleSplit;
      end
      sls_pkg::ModeLap: begin
        sec_d   = lap_d.s;
        ms_d    = lap_d.m;
        title_d = sls_pkg::TitleLap;
      end
      sls_pkg::ModeStopSplit: begin
        sec_d   = split_d.s;
        ms_d    = split_d.m;
        title_d = sls_pkg::TitleSplit;
        pmark_d = 1'b1;
      end
      sls_pkg::ModeStopLap: begin
        sec_d   = lap_d.s;
        ms_d    = lap_d.m;
        title_d = sls_pkg::TitleLap;
        pmark_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= sls_pkg::ModeStart;
      start_q <= sls_pkg::StampZero;
      last_q  <= sls_pkg::StampZero;
      split_q <= sls_pkg::StampZero;
      lap_q   <= sls_pkg::StampZero;
      pause_q <= sls_pkg::StampZero;
    end else if (in_fire) begin
      mode_q  <= mode_d;
      start_q <= start_d;
      last_q  <= last_d;
      split_q <= split_d;
      lap_q   <= lap_d;
      pause_q <= pause_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_limit_q <= sls_pkg::ResetFastLimitSec;
      fast_int_q   <= sls_pkg::ResetFastIntervalMs;
      slow_int_q   <= sls_pkg::ResetSlowIntervalMs;
    end else if (cfg_i.valid) begin
      case (sls_pkg::cfg_idx_e'(cfg_i.index))
        sls_pkg::CfgFastLimit:    fast_limit_q <= cfg_i.data;
        sls_pkg::CfgFastInterval: fast_int_q   <= cfg_i.data;
        sls_pkg::CfgSlowInterval: slow_int_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sec_q    <= sec_d;
      ms_q     <= ms_d;
      title_q  <= title_d;
      pmark_q  <= pmark_d;
      acc_q    <= acc_d;
      run_q    <= run_d;
      redraw_q <= redraw_d;
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.shown_sec          = sec_q;
  assign out_o.shown_ms           = ms_q;
  assign out_o.title_code         = title_q;
  assign out_o.paused_mark        = pmark_q;
  assign out_o.accepted           = acc_q;
  assign out_o.running            = run_q;
  assign out_o.redraw_interval_ms = redraw_q;

endmodule

/* sim/tb.sv */
// testbench for the stopwatch: directed table, then random commands checked by a predictor
module tb;

  localparam int          QuietLimit = 1000;
  localparam logic [1:0]  CfgUnused  = 2'd3;

  typedef struct packed {
    logic [31:0] sec;
    logic [9:0]  ms;
    logic [1:0]  title;
    logic        pmark;
    logic        acc;
    logic        run;
    logic [15:0] redraw;
  } display_t;

  typedef struct {
    sls_pkg::cmd_e c;
    logic [31:0]   s;
    logic [9:0]    m;
    bit            typed;
    display_t      want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  sls_in_if  in_if ();
  sls_out_if out_if ();
  sls_cfg_if cfg_if ();

  split_lap_stopwatch_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // stopwatch state as the predictor sees it
  sls_pkg::mode_e   sw_mode;
  sls_pkg::tstamp_t t_start, t_last, span_split, span_lap, t_pause;
  logic [15:0]      lim_fast_sec, ivl_fast, ivl_slow;

  display_t    shown_q[$];
  int          bad_count;
  int          burst_left;
  int          quiet_cycles = 0;
  logic [9:0]  rx_tick = '0;

  function automatic sls_pkg::tstamp_t stamp_diff(sls_pkg::tstamp_t a, sls_pkg::tstamp_t b);
    sls_pkg::tstamp_t r;
    r.s = a.s - b.s;
    if (a.m < b.m) begin
      r.m = 10'(int'(a.m) + 1000 - int'(b.m));
      r.s = r.s - 32'd1;
    end else begin
      r.m = a.m - b.m;
    end
    return r;
  endfunction

  function automatic sls_pkg::tstamp_t stamp_sum(sls_pkg::tstamp_t a, sls_pkg::tstamp_t b);
    sls_pkg::tstamp_t r;
    int               ms;
    ms  = int'(a.m) + int'(b.m);
    r.s = a.s + b.s;
    if (ms >= 1000) begin
      ms  = ms - 1000;
      r.s = r.s + 32'd1;
    end
    r.m = 10'(ms);
    return r;
  endfunction

  function automatic void clear_watch();
    sw_mode    = sls_pkg::ModeStart;
    t_start    = '0;
    t_last     = '0;
    span_split = '0;
    span_lap   = '0;
    t_pause    = '0;
  endfunction

  function automatic void take_split(sls_pkg::tstamp_t now);
    span_lap   = stamp_diff(now, t_last);
    span_split = stamp_diff(now, t_start);
    t_last     = now;
  endfunction

  function automatic display_t next_view(sls_pkg::cmd_e c, logic [31:0] s, logic [9:0] m);
    display_t         v;
    sls_pkg::tstamp_t now, gap, el;
    v       = '0;
    v.acc   = 1'b1;
    now.s   = s;
    now.m   = (m > 10'd999) ? 10'd999 : m;
    case (c)
      sls_pkg::CmdSelect: begin
        case (sw_mode)
          sls_pkg::ModeRun: begin
            t_pause = now;
            take_split(now);
            sw_mode = sls_pkg::ModeStopSplit;
          end
          sls_pkg::ModeStopLap, sls_pkg::ModeStopSplit: begin
            gap     = stamp_diff(now, t_pause);
            t_last  = stamp_sum(gap, t_last);
            t_start = stamp_sum(gap, t_start);
            sw_mode = sls_pkg::ModeRun;
          end
          sls_pkg::ModeSplit, sls_pkg::ModeLap: sw_mode = sls_pkg::ModeRun;
          default: begin
            t_start = now;
            t_last  = now;
            sw_mode = sls_pkg::ModeRun;
          end
        endcase
      end
      sls_pkg::CmdLongSelect: clear_watch();
      sls_pkg::CmdUp: begin
        case (sw_mode)
          sls_pkg::ModeRun: begin
            take_split(now);
            sw_mode = sls_pkg::ModeSplit;
          end
          sls_pkg::ModeStopLap:   sw_mode = sls_pkg::ModeStopSplit;
          sls_pkg::ModeStopSplit: sw_mode = sls_pkg::ModeStopLap;
          sls_pkg::ModeSplit:     sw_mode = sls_pkg::ModeLap;
          sls_pkg::ModeLap:       sw_mode = sls_pkg::ModeSplit;
          default:                v.acc = 1'b0;
        endcase
      end
      default: ;
    endcase
    case (sw_mode)
      sls_pkg::ModeRun: begin
        el       = stamp_diff(now, t_start);
        v.sec    = el.s;
        v.ms     = el.m + 10'd100 - (el.m % 10'd100);
        v.run    = 1'b1;
        v.redraw = (el.s < {16'd0, lim_fast_sec}) ? ivl_fast : ivl_slow;
      end
      sls_pkg::ModeSplit, sls_pkg::ModeStopSplit: begin
        v.sec   = span_split.s;
        v.ms    = span_split.m;
        v.title = sls_pkg::TitleSplit;
        v.pmark = (sw_mode == sls_pkg::ModeStopSplit);
      end
      sls_pkg::ModeLap, sls_pkg::ModeStopLap: begin
        v.sec   = span_lap.s;
        v.ms    = span_lap.m;
        v.title = sls_pkg::TitleLap;
        v.pmark = (sw_mode == sls_pkg::ModeStopLap);
      end
      default: ;
    endcase
    return v;
  endfunction

  task automatic note_bad(string what, display_t e, display_t a);
    bad_count++;
    if (bad_count <= 10) begin
      $display("%s exp sec=%0d ms=%0d title=%0d pm=%0d acc=%0d run=%0d redraw=%0d",
               what, e.sec, e.ms, e.title, e.pmark, e.acc, e.run, e.redraw);
      $display("  act sec=%0d ms=%0d title=%0d pm=%0d acc=%0d run=%0d redraw=%0d",
               a.sec, a.ms, a.title, a.pmark, a.acc, a.run, a.redraw);
    end
  endtask

  // command request, sent in bursts with random gaps
  task automatic send_cmd(sls_pkg::cmd_e c, logic [31:0] s, logic [9:0] m, bit typed,
                          display_t want);
    int       gap;
    display_t pred;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? 100 : $urandom_range(1, 12);
    end
    burst_left--;
    in_if.valid   <= 1'b1;
    in_if.command <= c;
    in_if.now_sec <= s;
    in_if.now_ms  <= m;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    pred = next_view(c, s, m);
    shown_q.push_back(typed ? want : pred);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (shown_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic set_regs(logic [15:0] lim, logic [15:0] fast, logic [15:0] slow, bit poke);
    logic [1:0]  idx [4];
    logic [15:0] val [4];
    int          n;
    idx = '{sls_pkg::CfgFastLimit, sls_pkg::CfgFastInterval, sls_pkg::CfgSlowInterval,
            CfgUnused};
    val = '{lim, fast, slow, 16'($urandom)};
    n   = poke ? 4 : 3;
    for (int i = 0; i < n; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx[i];
      cfg_if.data  <= val[i];
      @(posedge clk_i);
      while (!cfg_if.ready) @(posedge clk_i);
      case (idx[i])
        sls_pkg::CfgFastLimit:    lim_fast_sec = val[i];
        sls_pkg::CfgFastInterval: ivl_fast = val[i];
        sls_pkg::CfgSlowInterval: ivl_slow = val[i];
        default: ;
      endcase
    end
    cfg_if.valid <= 1'b0;
  endtask

  // display request checker with its own stall pattern
  always @(posedge clk_i) begin
    display_t act;
    display_t exp;
    rx_tick <= rx_tick + 10'd1;
    case (rx_tick[9:8])
      2'd0: out_if.ready <= 1'b1;
      2'd1: out_if.ready <= 1'($urandom_range(0, 1));
      2'd2: out_if.ready <= (rx_tick[2:0] == 3'd0);
      default: out_if.ready <= ($urandom_range(0, 3) != 0);
    endcase
    if (rst_ni && out_if.valid && out_if.ready) begin
      act = '{out_if.shown_sec, out_if.shown_ms, out_if.title_code, out_if.paused_mark,
              out_if.accepted, out_if.running, out_if.redraw_interval_ms};
      if (shown_q.size() == 0) begin
        note_bad("unexpected result", '0, act);
      end else begin
        exp = shown_q.pop_front();
        if (act.sec !== exp.sec || act.ms !== exp.ms || act.title !== exp.title ||
            act.pmark !== exp.pmark || act.acc !== exp.acc || act.run !== exp.run ||
            act.redraw !== exp.redraw)
          note_bad("mismatch", exp, act);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    row_t             dir_rows[$];
    sls_pkg::tstamp_t wall;
    logic [9:0]       ms_drive;
    sls_pkg::cmd_e    c;
    int               r;
    int               ms_sum;
    logic [15:0]      phase_cfg [6][3];

    in_if.valid   <= 1'b0;
    in_if.command <= sls_pkg::CmdRefresh;
    in_if.now_sec <= '0;
    in_if.now_ms  <= '0;
    cfg_if.valid  <= 1'b0;
    cfg_if.index  <= sls_pkg::CfgFastLimit;
    cfg_if.data   <= '0;
    bad_count     = 0;
    burst_left    = 0;
    clear_watch();
    lim_fast_sec  = sls_pkg::ResetFastLimitSec;
    ivl_fast      = sls_pkg::ResetFastIntervalMs;
    ivl_slow      = sls_pkg::ResetSlowIntervalMs;

    phase_cfg = '{'{16'd300, 16'd200, 16'd1000},
                  '{16'd0, 16'd0, 16'd65535},
                  '{16'd65535, 16'd0, 16'd1},
                  '{16'd65535, 16'd65535, 16'd0},
                  '{16'd0, 16'd1, 16'd1},
                  '{16'd300, 16'd200, 16'd1000}};

    dir_rows.push_back('{sls_pkg::CmdUp, 32'd0, 10'd0, 1'b1,
                         '{32'd0, 10'd0, sls_pkg::TitleMain, 1'b0, 1'b0, 1'b0, 16'd0}});
    dir_rows.push_back('{sls_pkg::CmdRefresh, 32'd5, 10'd5, 1'b1,
                         '{32'd0, 10'd0, sls_pkg::TitleMain, 1'b0, 1'b1, 1'b0, 16'd0}});
    dir_rows.push_back('{sls_pkg::CmdSelect, 32'd10, 10'd0, 1'b1,
                         '{32'd0, 10'd100, sls_pkg::TitleMain, 1'b0, 1'b1, 1'b1, 16'd200}});
    dir_rows.push_back('{sls_pkg::CmdRefresh, 32'd10, 10'd999, 1'b1,
                         '{32'd0, 10'd1000, sls_pkg::TitleMain, 1'b0, 1'b1, 1'b1, 16'd200}});
    dir_rows.push_back('{sls_pkg::CmdRefresh, 32'd310, 10'd50, 1'b0, '0});
    dir_rows.push_back('{sls_pkg::CmdUp, 32'd311, 10'd1023, 1'b0, '0});
    dir_rows.push_back('{sls_pkg::CmdUp, 32'd312, 10'd0, 1'b0, '0});
    dir_rows.push_back('{sls_pkg::CmdUp, 32'd313, 10'd0, 1'b0, '0});
    dir_rows.push_back('{sls_pkg::CmdSelect, 32'd314, 10'd1, 1'b0, '0});
    dir_rows.push_back('{sls_pkg::CmdSelect, 32'hFFFF_FFFF, 10'd998, 1'b0, '0});
    dir_rows.push_back('{sls_pkg::CmdUp, 32'd0, 10'd0, 1'b0, '0});
    dir_rows.push_back('{sls_pkg::CmdUp, 32'd0, 10'd1, 1'b0, '0});
    dir_rows.push_back('{sls_pkg::CmdRefresh, 32'd0, 10'd2, 1'b0, '0});
    dir_rows.push_back('{sls_pkg::CmdSelect, 32'd2, 10'd5, 1'b0, '0});
    dir_rows.push_back('{sls_pkg::CmdRefresh, 32'd3, 10'd1000, 1'b0, '0});
    dir_rows.push_back('{sls_pkg::CmdUp, 32'd4, 10'd7, 1'b0, '0});
    dir_rows.push_back('{sls_pkg::CmdLongSelect, 32'd5, 10'd0, 1'b1,
                         '{32'd0, 10'd0, sls_pkg::TitleMain, 1'b0, 1'b1, 1'b0, 16'd0}});
    dir_rows.push_back('{sls_pkg::CmdSelect, 32'hFFFF_FFFF, 10'd999, 1'b0, '0});
    dir_rows.push_back('{sls_pkg::CmdRefresh, 32'd0, 10'd0, 1'b0, '0});
    dir_rows.push_back('{sls_pkg::CmdSelect, 32'd1, 10'd500, 1'b0, '0});
    dir_rows.push_back('{sls_pkg::CmdLongSelect, 32'd2, 10'd0, 1'b1,
                         '{32'd0, 10'd0, sls_pkg::TitleMain, 1'b0, 1'b1, 1'b0, 16'd0}});
    dir_rows.push_back('{sls_pkg::CmdSelect, 32'd123, 10'd456, 1'b0, '0});

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i])
      send_cmd(dir_rows[i].c, dir_rows[i].s, dir_rows[i].m, dir_rows[i].typed,
               dir_rows[i].want);

    wall = '{s: 32'd200, m: 10'd0};
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        drain();
        if (ph == 4)
          set_regs(16'($urandom_range(0, 600)), 16'($urandom_range(1, 65535)),
                   16'($urandom_range(1, 65535)), 1'b0);
        else
          set_regs(phase_cfg[ph][0], phase_cfg[ph][1], phase_cfg[ph][2], ph == 1);
      end
      for (int k = 0; k < 285; k++) begin
        r = $urandom_range(0, 99);
        if (r < 6) begin
          wall.s = $urandom;
          wall.m = 10'($urandom_range(0, 999));
        end else if (r < 14) begin
          wall.s = wall.s + $urandom_range(1, 1200);
        end else begin
          ms_sum = int'(wall.m) + $urandom_range(0, 2500);
          wall.s = wall.s + 32'(ms_sum / 1000);
          wall.m = 10'(ms_sum % 1000);
        end
        ms_drive = wall.m;
        if ($urandom_range(0, 39) == 0)
          ms_drive = 10'($urandom_range(1000, 1023));
        r = $urandom_range(0, 99);
        if (r < 6)
          c = sls_pkg::CmdLongSelect;
        else if (r < 36)
          c = sls_pkg::CmdSelect;
        else if (r < 70)
          c = sls_pkg::CmdUp;
        else
          c = sls_pkg::CmdRefresh;
        send_cmd(c, wall.s, ms_drive, 1'b0, '0);
      end
    end

    drain();
    repeat (4) @(posedge clk_i);
    bad_count = bad_count + shown_q.size();
    if (bad_count == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule

/* files.f */
src/sls_pkg.sv
src/sls_if.sv
src/split_lap_stopwatch_top.sv
sim/tb.sv
